// ===== rtl/core/grp_pkg.sv =====
// Shared types and constants for the guillotine rectangle packer.
// Depends on nothing; used by the controller, datapath and top level.
package grp_pkg;

    // result status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_TOO_LARGE = 2'd1;
    localparam logic [1:0] ST_LIST_FULL = 2'd2;
    localparam logic [1:0] ST_NO_BINS   = 2'd3;

    // controller state, one-hot
    typedef enum logic [7:0] {
        S_IDLE  = 8'b00000001,
        S_SCAN  = 8'b00000010,
        S_WAIT  = 8'b00000100,
        S_DRAIN = 8'b00001000,
        S_DEC   = 8'b00010000,
        S_SHIFT = 8'b00100000,
        S_APP   = 8'b01000000,
        S_OUT   = 8'b10000000
    } t_state;

    // controller to datapath commands
    typedef struct packed {
        logic load;     // capture request, clear scan
        logic rd;       // issue memory read at scan address
        logic cmp;      // compare registered read data
        logic decide;   // settle chosen entry and error status
        logic shift_rd; // read the next entry to move down
        logic shift_wr; // write previous read to shift address
        logic app;      // write one appended piece
        logic commit;   // update counts
    } t_cmd;

    // datapath to controller status
    typedef struct packed {
        logic scan_last;
        logic err;
        logic shift_done;
        logic app_done;
    } t_stat;

endpackage

// ===== rtl/core/grp_ctrl.sv =====
// Sequencer for the packer: scan, decide, compact, append, respond.
// Depends on grp_pkg.
module grp_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    output logic           o_valid,
    input  logic           i_ready,
    input  grp_pkg::t_stat i_stat,
    output grp_pkg::t_cmd  o_cmd
);

    grp_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= grp_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_ready = (r_state == grp_pkg::S_IDLE);
    assign o_valid = (r_state == grp_pkg::S_OUT);

    // next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            grp_pkg::S_IDLE: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = grp_pkg::S_SCAN;
                end
            end
            grp_pkg::S_SCAN: begin
                o_cmd.rd  = 1'b1;
                o_cmd.cmp = 1'b1;
                if (i_stat.scan_last) n_state = grp_pkg::S_WAIT;
            end
            grp_pkg::S_WAIT: begin
                o_cmd.cmp = 1'b1;
                n_state   = grp_pkg::S_DRAIN;
            end
            // let the last compare land in the best-fit registers
            grp_pkg::S_DRAIN: begin
                n_state = grp_pkg::S_DEC;
            end
            grp_pkg::S_DEC: begin
                o_cmd.decide = 1'b1;
                n_state      = grp_pkg::S_SHIFT;
            end
            grp_pkg::S_SHIFT: begin
                if (i_stat.err) begin
                    n_state = grp_pkg::S_OUT;
                end else if (i_stat.shift_done) begin
                    n_state = grp_pkg::S_APP;
                end else begin
                    o_cmd.shift_rd = 1'b1;
                    o_cmd.shift_wr = 1'b1;
                end
            end
            grp_pkg::S_APP: begin
                if (i_stat.app_done) begin
                    o_cmd.commit = 1'b1;
                    n_state      = grp_pkg::S_OUT;
                end else begin
                    o_cmd.app = 1'b1;
                end
            end
            grp_pkg::S_OUT: begin
                if (i_ready) n_state = grp_pkg::S_IDLE;
            end
            default: n_state = grp_pkg::S_IDLE;
        endcase
    end

endmodule

// ===== rtl/core/grp_dp.sv =====
// Datapath for the packer: free-rectangle memory, best-fit compare,
// compaction and piece append. Depends on grp_pkg.
module grp_dp #(
    parameter int BIN_SIZE = 1024,
    parameter int MAX_FREE = 64,
    parameter int MAX_BINS = 256
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic [10:0]    i_req_width,
    input  logic [10:0]    i_req_height,
    input  grp_pkg::t_cmd  i_cmd,
    output grp_pkg::t_stat o_stat,
    output logic [7:0]     o_bin_index,
    output logic [9:0]     o_pos_x,
    output logic [9:0]     o_pos_y,
    output logic [1:0]     o_status
);

    localparam int AW = (MAX_FREE > 1) ? $clog2(MAX_FREE) : 1;
    localparam int CW = $clog2(MAX_FREE + 1);
    localparam int BW = $clog2(MAX_BINS + 1);
    localparam int BNW = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
    localparam int SW = $clog2(BIN_SIZE + 1);
    localparam int PW = 2 * SW;

    typedef struct packed {
        logic [BNW-1:0] bin;
        logic [SW-1:0]  x;
        logic [SW-1:0]  y;
        logic [SW-1:0]  w;
        logic [SW-1:0]  h;
    } t_ent;

    localparam t_ent FULL0 = '{bin: '0, x: '0, y: '0,
                               w: SW'(BIN_SIZE), h: SW'(BIN_SIZE)};

    t_ent mem [MAX_FREE];
    t_ent r_rd;
    logic r_ent0_wr;          // entry 0 written since reset
    logic r_rd_zero;          // registered read was of never-written entry 0

    logic [CW-1:0]  r_count;
    logic [BW-1:0]  r_bins;
    logic [SW-1:0]  r_rw, r_rh;
    logic           r_big;
    logic [CW-1:0]  r_scan;     // next read address
    logic [CW-1:0]  r_cidx;     // index of data in r_rd
    logic           r_cvld;
    logic           r_found;
    logic [AW-1:0]  r_match;
    logic [PW-1:0]  r_best;
    t_ent           r_best_e;
    t_ent           r_chosen;
    logic [CW-1:0]  r_base;
    logic [1:0]     r_status;
    logic [CW-1:0]  r_sh;       // shift destination
    logic           r_sh_pend;  // r_rd holds the entry for r_sh
    logic           r_below, r_right;
    logic [PW-1:0]  r_req_area;
    logic [PW-1:0]  r_ent_area;
    logic           r_fit;
    logic [AW-1:0]  r_fidx;
    t_ent           r_fe;
    logic           r_fvld;

    t_ent rd_ent;
    assign rd_ent = r_rd_zero ? FULL0 : r_rd;

    // oversize request flags
    logic req_big_w, req_big_h;
    assign req_big_w = 32'(i_req_width) > 32'(BIN_SIZE);
    assign req_big_h = 32'(i_req_height) > 32'(BIN_SIZE);

    // write port select
    logic           wr_en;
    logic [AW-1:0]  wr_addr;
    t_ent           wr_data;
    logic [AW-1:0]  rd_addr;

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_sh[AW-1:0];
        wr_data = rd_ent;
        rd_addr = r_scan[AW-1:0];
        // keep the read one entry ahead of the write while compacting
        if (i_cmd.shift_rd) rd_addr = AW'(r_sh + (r_sh_pend ? CW'(2) : CW'(1)));
        if (i_cmd.shift_wr && r_sh_pend) wr_en = 1'b1;
        if (i_cmd.app) begin
            wr_en   = 1'b1;
            wr_addr = r_base[AW-1:0];
            if (r_below) begin
                wr_data = '{bin: r_chosen.bin, x: r_chosen.x,
                            y: SW'(r_chosen.y + r_rh), w: r_chosen.w,
                            h: SW'(r_chosen.h - r_rh)};
            end else begin
                wr_data = '{bin: r_chosen.bin, x: SW'(r_chosen.x + r_rw),
                            y: r_chosen.y, w: SW'(r_chosen.w - r_rw), h: r_rh};
            end
        end
    end

    // memory
    always_ff @(posedge i_clk) begin
        if (wr_en) mem[wr_addr] <= wr_data;
        r_rd <= mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ent0_wr <= 1'b0;
        end else if (wr_en && wr_addr == '0) begin
            r_ent0_wr <= 1'b1;
        end
        r_rd_zero <= (rd_addr == '0) && !(r_ent0_wr || (wr_en && wr_addr == '0));
    end

    // stage 1 of compare: fit and areas
    always_ff @(posedge i_clk) begin
        r_fvld     <= i_cmd.cmp && r_cvld;
        r_fit      <= (r_rw <= rd_ent.w) && (r_rh <= rd_ent.h);
        r_ent_area <= PW'(rd_ent.w) * PW'(rd_ent.h);
        r_fidx     <= r_cidx[AW-1:0];
        r_fe       <= rd_ent;
    end

    logic [PW-1:0] diff;
    assign diff = r_ent_area - r_req_area;

    logic [CW:0] need;
    always_comb begin
        need = {1'b0, r_base} + (CW+1)'(r_below) + (CW+1)'(r_right);
    end

    // placement shape and error status for the decide step
    logic [CW-1:0] dec_base;
    logic          dec_below, dec_right;
    logic [CW:0]   dec_need;
    logic [1:0]    dec_status;

    always_comb begin
        if (r_found) begin
            dec_base  = r_count - CW'(1);
            dec_below = r_best_e.h > r_rh;
            dec_right = r_best_e.w > r_rw;
        end else begin
            dec_base  = r_count;
            dec_below = SW'(BIN_SIZE) > r_rh;
            dec_right = SW'(BIN_SIZE) > r_rw;
        end
        dec_need   = {1'b0, dec_base} + (CW+1)'(dec_below) + (CW+1)'(dec_right);
        dec_status = grp_pkg::ST_OK;
        if (r_big) dec_status = grp_pkg::ST_TOO_LARGE;
        else if (!r_found && r_bins >= BW'(MAX_BINS)) dec_status = grp_pkg::ST_NO_BINS;
        else if (dec_need > (CW+1)'(MAX_FREE)) dec_status = grp_pkg::ST_LIST_FULL;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= CW'(1);
            r_bins  <= BW'(1);
        end else if (i_cmd.commit) begin
            r_count <= CW'(need);
            if (!r_found) r_bins <= r_bins + BW'(1);
        end
        if (i_cmd.load) begin
            r_rw       <= req_big_w ? '0 : SW'(i_req_width);
            r_rh       <= req_big_h ? '0 : SW'(i_req_height);
            r_big      <= req_big_w || req_big_h;
            r_req_area <= PW'(i_req_width) * PW'(i_req_height);
            r_scan     <= '0;
            r_found    <= 1'b0;
            r_cvld     <= 1'b0;
        end
        if (i_cmd.rd) begin
            r_cidx <= r_scan;
            r_cvld <= r_scan < r_count;
            r_scan <= r_scan + CW'(1);
        end else if (i_cmd.cmp) begin
            r_cvld <= 1'b0;
        end
        if (r_fvld && r_fit && (!r_found || diff < r_best)) begin
            r_found <= 1'b1;
            r_match <= r_fidx;
            r_best  <= diff;
            r_best_e <= r_fe;
        end
        if (i_cmd.decide) begin
            if (r_found) begin
                r_chosen <= r_best_e;
                r_sh     <= CW'(r_match);
            end else begin
                r_chosen <= '{bin: BNW'(r_bins), x: '0, y: '0,
                              w: SW'(BIN_SIZE), h: SW'(BIN_SIZE)};
                r_sh     <= r_count;
            end
            r_base    <= dec_base;
            r_below   <= dec_below;
            r_right   <= dec_right;
            r_status  <= dec_status;
            r_sh_pend <= 1'b0;
        end
        // advance the move; stop reading once the last entry is in hand
        if (i_cmd.shift_rd) begin
            if (r_sh_pend) begin
                r_sh      <= r_sh + CW'(1);
                r_sh_pend <= (r_sh + CW'(2)) < r_count;
            end else begin
                r_sh_pend <= 1'b1;
            end
        end
        if (i_cmd.app) begin
            r_base <= r_base + CW'(1);
            if (r_below) r_below <= 1'b0;
            else         r_right <= 1'b0;
        end
    end

    // the scan always walks the full table; entries past the count are ignored
    assign o_stat.scan_last = (r_scan == CW'(MAX_FREE - 1)) && i_cmd.rd;
    assign o_stat.err       = (r_status != grp_pkg::ST_OK);
    assign o_stat.shift_done = r_found ? (!r_sh_pend && (r_sh + CW'(1) >= r_count)) : 1'b1;
    assign o_stat.app_done  = !r_below && !r_right;

    assign o_status    = r_status;
    assign o_bin_index = o_stat.err ? '0 : 8'(r_chosen.bin);
    assign o_pos_x     = o_stat.err ? '0 : 10'(r_chosen.x);
    assign o_pos_y     = o_stat.err ? '0 : 10'(r_chosen.y);

endmodule

// ===== rtl/core/guillotine_rect_packer.sv =====
// Guillotine best-area-fit rectangle packer, top level.
// Each item runs through the scan, drain and decide steps, then, unless the request
// fails, compaction of the free list and the append of the leftover pieces before the result item is offered.
// One item at a time: the scan and compaction both go through the free-list
// memory's single read port.
// Reset (synchronous, active low) leaves one free entry, the full bin 0.
module guillotine_rect_packer #(
    parameter int BIN_SIZE = 1024,
    parameter int MAX_FREE = 64,
    parameter int MAX_BINS = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [10:0] i_req_width,
    input  logic [10:0] i_req_height,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [7:0]  o_bin_index,
    output logic [9:0]  o_pos_x,
    output logic [9:0]  o_pos_y,
    output logic [1:0]  o_status
);

    grp_pkg::t_cmd  cmd;
    grp_pkg::t_stat stat;

    grp_ctrl u_ctrl (
        .i_clk, .i_rst_n, .i_valid, .o_ready, .o_valid, .i_ready,
        .i_stat(stat), .o_cmd(cmd)
    );

    grp_dp #(.BIN_SIZE(BIN_SIZE), .MAX_FREE(MAX_FREE), .MAX_BINS(MAX_BINS)) u_dp (
        .i_clk, .i_rst_n, .i_req_width, .i_req_height,
        .i_cmd(cmd), .o_stat(stat),
        .o_bin_index, .o_pos_x, .o_pos_y, .o_status
    );

`ifndef SYNTHESIS
    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_ready && o_valid)) else $error("ready and valid together");
    a_errz: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status != grp_pkg::ST_OK) |-> (o_pos_x == '0 && o_pos_y == '0))
        else $error("error result carries position");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> o_valid) else $error("result dropped");
`endif

endmodule

// ===== test/tb_guillotine_rect_packer.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for guillotine_rect_packer: predicts each placement in the
// testbench and compares every result item field by field. Depends on grp_pkg and the DUT.
module tb_guillotine_rect_packer;

    localparam int BIN_SIZE = 1024;
    localparam int MAX_FREE = 64;
    localparam int MAX_BINS = 256;
    localparam int HOLD_CYCLES = 400;
    localparam int STALL_LIMIT = 4000;

    typedef struct {
        int unsigned bin;
        int unsigned x;
        int unsigned y;
        int unsigned w;
        int unsigned h;
    } t_free_rect;

    typedef struct packed {
        logic [7:0] bin;
        logic [9:0] x;
        logic [9:0] y;
        logic [1:0] status;
    } t_placement;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic [10:0] i_req_width;
    logic [10:0] i_req_height;
    logic        o_valid;
    logic        i_ready;
    logic [7:0]  o_bin_index;
    logic [9:0]  o_pos_x;
    logic [9:0]  o_pos_y;
    logic [1:0]  o_status;

    // packer state mirrored by the predictor
    t_free_rect  free_list[MAX_FREE];
    int unsigned free_count;
    int unsigned bins_open;

    t_placement  pending_placements[$];
    int          mismatches;
    bit          calm;
    bit          hold_request;
    int          hold_left;
    int          stall_cycles;
    int          no_bins_seen;

    guillotine_rect_packer #(
        .BIN_SIZE(BIN_SIZE),
        .MAX_FREE(MAX_FREE),
        .MAX_BINS(MAX_BINS)
    ) i_dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_ready(o_ready),
        .i_req_width(i_req_width),
        .i_req_height(i_req_height),
        .o_valid(o_valid),
        .i_ready(i_ready),
        .o_bin_index(o_bin_index),
        .o_pos_x(o_pos_x),
        .o_pos_y(o_pos_y),
        .o_status(o_status)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Best-area-fit placement: update the mirrored free list, return the placement
    function automatic t_placement place_rect(int unsigned rw, int unsigned rh);
        t_placement  res;
        t_free_rect  chosen;
        bit          found;
        int unsigned match;
        longint unsigned best;
        longint unsigned diff;
        int unsigned base;
        int unsigned pieces;
        res = '0;
        found = 0;
        match = 0;
        best = 0;
        if (rw > BIN_SIZE || rh > BIN_SIZE) begin
            res.status = grp_pkg::ST_TOO_LARGE;
            return res;
        end
        for (int i = 0; i < free_count; i++) begin
            if (rw <= free_list[i].w && rh <= free_list[i].h) begin
                diff = longint'(free_list[i].w) * free_list[i].h - longint'(rw) * rh;
                if (!found || diff < best) begin
                    found = 1;
                    match = i;
                    best = diff;
                end
            end
        end
        if (found) begin
            chosen = free_list[match];
            base = free_count - 1;
        end else begin
            if (bins_open >= MAX_BINS) begin
                res.status = grp_pkg::ST_NO_BINS;
                return res;
            end
            chosen = '{bins_open, 0, 0, BIN_SIZE, BIN_SIZE};
            base = free_count;
        end
        pieces = (chosen.h > rh) + (chosen.w > rw);
        if (base + pieces > MAX_FREE) begin
            res.status = grp_pkg::ST_LIST_FULL;
            return res;
        end
        // close the gap, or take a fresh bin
        if (found) begin
            for (int i = match; i + 1 < free_count; i++) free_list[i] = free_list[i + 1];
        end else begin
            bins_open++;
        end
        // append the part below, then the part to the right
        if (chosen.h > rh) begin
            free_list[base] = '{chosen.bin, chosen.x, chosen.y + rh, chosen.w, chosen.h - rh};
            base++;
        end
        if (chosen.w > rw) begin
            free_list[base] = '{chosen.bin, chosen.x + rw, chosen.y, chosen.w - rw, rh};
            base++;
        end
        free_count = base;
        res.bin = chosen.bin[7:0];
        res.x = chosen.x[9:0];
        res.y = chosen.y[9:0];
        res.status = grp_pkg::ST_OK;
        return res;
    endfunction

    // Offer one item, hold it until accepted, then record the expected placement
    task automatic send_rect(int unsigned rw, int unsigned rh);
        t_placement exp_p;
        if (!calm && $urandom_range(0, 99) < 30) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_req_width <= rw[10:0];
        i_req_height <= rh[10:0];
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        exp_p = place_rect(rw, rh);
        if (exp_p.status == grp_pkg::ST_NO_BINS) no_bins_seen++;
        pending_placements = {pending_placements, exp_p};
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_placements.size() != 0) @(posedge i_clk);
    endtask

    // Random request size: mostly small, some zero, oversize and full-range
    task automatic send_random_rect();
        int unsigned pick;
        int unsigned rw;
        int unsigned rh;
        pick = $urandom_range(0, 99);
        if (pick < 60) begin
            rw = $urandom_range(1, 200);
            rh = $urandom_range(1, 128);
        end else if (pick < 70) begin
            rw = $urandom_range(0, 1) ? 0 : $urandom_range(0, 64);
            rh = rw != 0 ? 0 : $urandom_range(0, 64);
        end else if (pick < 80) begin
            rw = $urandom_range(0, 2047);
            rh = $urandom_range(0, 2047);
        end else begin
            rw = $urandom_range(0, BIN_SIZE);
            rh = $urandom_range(0, BIN_SIZE);
        end
        send_rect(rw, rh);
    endtask

    task automatic test_directed();
        send_rect(BIN_SIZE, BIN_SIZE);     // exact fit, no leftover
        send_rect(0, 0);                   // zero-size opens a fresh bin
        send_rect(BIN_SIZE + 1, 5);        // too wide
        send_rect(5, BIN_SIZE + 1);        // too tall
        send_rect(2047, 2047);
        send_rect(BIN_SIZE, 0);
        send_rect(0, BIN_SIZE);
        send_rect(11'h555, 11'h2AA);
        send_rect(11'h2AA, 11'h555);
        send_rect(11'h2AA, 11'h2AA);
        send_rect(1023, 1023);
        send_rect(1, 1);
        send_rect(512, 512);
        send_rect(512, 256);
        send_rect(1, BIN_SIZE);
        send_rect(BIN_SIZE, 1);
        send_rect(0, 7);
        send_rect(9, 0);
        wait_drained();
    endtask

    task automatic test_random();
        for (int n = 0; n < 900; n++) begin
            calm = (n >= 300 && n < 450);
            send_random_rect();
        end
        calm = 0;
    endtask

    // Receiver holds off while the sender keeps offering, then the sender pauses
    task automatic test_backpressure();
        hold_request = 1;
        for (int n = 0; n < 20; n++) send_random_rect();
        wait_drained();
    endtask

    // Full-bin requests until the bin supply runs out
    task automatic test_bins_exhausted();
        for (int n = 0; n < 300 && no_bins_seen < 4; n++) send_rect(BIN_SIZE, BIN_SIZE);
        wait_drained();
    endtask

    task automatic check_result();
        t_placement exp_p;
        if (pending_placements.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result item: bin %0d status %0d",
                                           o_bin_index, o_status);
            return;
        end
        exp_p = pending_placements.pop_front();
        if (o_bin_index !== exp_p.bin || o_pos_x !== exp_p.x || o_pos_y !== exp_p.y ||
            o_status !== exp_p.status) begin
            mismatches++;
            if (mismatches <= 10)
                $display({"mismatch: exp bin %0d x %0d y %0d st %0d, ",
                          "got bin %0d x %0d y %0d st %0d"},
                         exp_p.bin, exp_p.x, exp_p.y, exp_p.status,
                         o_bin_index, o_pos_x, o_pos_y, o_status);
        end
    endtask

    // Receiver: check each result item, then pick the next ready level
    initial begin
        i_ready = 1'b0;
        hold_left = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_valid && i_ready) check_result();
            if (hold_left > 0) begin
                hold_left--;
                i_ready <= 1'b0;
            end else if (hold_request) begin
                hold_request = 0;
                hold_left = HOLD_CYCLES;
                i_ready <= 1'b0;
            end else begin
                i_ready <= calm ? 1'b1 : ($urandom_range(0, 99) >= 30);
            end
        end
    end

    // Watchdog: end the run if nothing moves for too long
    initial begin
        stall_cycles = 0;
        forever begin
            @(posedge i_clk);
            if ((i_valid && o_ready) || (o_valid && i_ready)) stall_cycles = 0;
            else stall_cycles++;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("timeout: no item moved for %0d cycles", STALL_LIMIT);
                $display("guillotine_rect_packer regression: fail");
                $finish;
            end
        end
    end

    initial begin
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_req_width = '0;
        i_req_height = '0;
        mismatches = 0;
        calm = 0;
        hold_request = 0;
        no_bins_seen = 0;
        free_list[0] = '{0, 0, 0, BIN_SIZE, BIN_SIZE};
        free_count = 1;
        bins_open = 1;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random();
        test_backpressure();
        test_bins_exhausted();
        // let any stray result item show up
        repeat (300) @(posedge i_clk);
        if (mismatches == 0 && pending_placements.size() == 0) begin
            $display("guillotine_rect_packer regression: pass");
        end else begin
            $display("guillotine_rect_packer regression: fail");
        end
        $finish;
    end
endmodule

// ===== filelist.f =====
rtl/core/grp_pkg.sv
rtl/core/grp_ctrl.sv
rtl/core/grp_dp.sv
rtl/core/guillotine_rect_packer.sv
test/tb_guillotine_rect_packer.sv
